/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the histogram core. Each macro uses
// the clock clk and the synchronous reset rst of the module that uses it.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define PHE_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The condition must never be true.
`define PHE_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error(msg);

`else

`define PHE_ASSERT_IMPL(label, ante, cons, msg)
`define PHE_ASSERT_NEVER(label, cond, msg)

`endif

`endif

/* rtl/core/phe_pkg.sv */
// ----------------------------------------------------------------------------
// phe_pkg
// Constants, codes and the queue word type shared by the histogram core.
// ----------------------------------------------------------------------------
`default_nettype none

package phe_pkg;

  // Store geometry.
  localparam int MAX_BINS    = 128;
  localparam int COUNT_WIDTH = 32;
  localparam int SUM_WIDTH   = 48;
  localparam int SPECIES     = 3;
  localparam int SPECIES_W   = 2;
  localparam int BIN_W       = $clog2(MAX_BINS);
  localparam int MEM_DEPTH   = SPECIES * MAX_BINS;
  localparam int ADDR_W      = $clog2(MEM_DEPTH);

  // Field and register widths.
  localparam int FUNC_W      = 2;
  localparam int CODE_W      = 8;
  localparam int ENERGY_W    = 20;
  localparam int BIDX_W      = 7;
  localparam int OFFSET_W    = 20;
  localparam int SCALE_W     = 24;
  localparam int NBINS_W     = 8;
  localparam int FRAC_W      = 24;
  localparam int PROD_W      = ENERGY_W + SCALE_W;
  localparam int RAW_BIN_W   = PROD_W - FRAC_W;
  localparam int OUT_COUNT_W = 32;
  localparam int OUT_SUM_W   = 48;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 24;

  // Queue between front and back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Register reset values.
  localparam logic [OFFSET_W-1:0] OFFSET_RESET = 20'd0;
  localparam logic [SCALE_W-1:0]  SCALE_RESET  = 24'd167773;
  localparam logic [NBINS_W-1:0]  NBINS_RESET  = 8'd100;

  // Function codes of an input word.
  localparam logic [FUNC_W-1:0] FUNC_RECORD   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_READ_BIN = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ_TOT = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_OFFSET = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SCALE  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_NBINS  = 2'd2;

  // Operations carried from front to back.
  localparam int OP_W = 3;
  localparam logic [OP_W-1:0] OP_COUNT     = 3'd0; // record of unknown type
  localparam logic [OP_W-1:0] OP_RECORD    = 3'd1; // record of a known species
  localparam logic [OP_W-1:0] OP_READ_BIN  = 3'd2;
  localparam logic [OP_W-1:0] OP_READ_TOT  = 3'd3;
  localparam logic [OP_W-1:0] OP_READ_NONE = 3'd4; // read that returns only the total

  typedef struct packed {
    logic [OP_W-1:0]      op;
    logic [SPECIES_W-1:0] species;
    logic [ADDR_W-1:0]    addr;
    logic [ENERGY_W-1:0]  energy;
    logic                 hit;
  } phe_item_t;

endpackage

`default_nettype wire

/* rtl/core/phe_front.sv */
// ----------------------------------------------------------------------------
// phe_front
// Accepts input words, decodes the function and particle type, and computes
// the scaled bin of a record. One register stage feeds the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module phe_front (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [phe_pkg::FUNC_W-1:0]     func,
  input  wire logic signed [phe_pkg::CODE_W-1:0] particle_code,
  input  wire logic [phe_pkg::ENERGY_W-1:0]   energy_kev,
  input  wire logic [phe_pkg::SPECIES_W-1:0]  species_select,
  input  wire logic [phe_pkg::BIDX_W-1:0]     bin_index,
  input  wire logic [phe_pkg::OFFSET_W-1:0]   energy_offset_kev,
  input  wire logic [phe_pkg::SCALE_W-1:0]    bin_scale,
  input  wire logic [phe_pkg::NBINS_W-1:0]    num_bins,
  input  wire logic                           clearing,
  input  wire logic                           q_full,
  output logic                                q_push,
  output phe_pkg::phe_item_t                  q_item
);
  import phe_pkg::*;

  logic                 f_valid;
  logic [OP_W-1:0]      f_op;
  logic [SPECIES_W-1:0] f_species;
  logic [ENERGY_W-1:0]  f_energy;
  logic [BIN_W-1:0]     f_index;
  logic                 f_below;
  logic [PROD_W-1:0]    f_prod;

  logic                 accept;
  logic                 work;
  logic [OP_W-1:0]      op_dec;
  logic [SPECIES_W-1:0] species_dec;
  logic [CODE_W-1:0]    mag;
  logic [CODE_W-1:0]    mag_m1;
  logic                 known;
  logic [ENERGY_W:0]    diff;
  logic [PROD_W-1:0]    prod;
  logic [RAW_BIN_W-1:0] raw_bin;
  logic [BIN_W-1:0]     slot;

  // Handshake: hold off while the store is cleared or the word cannot move on.
  assign in_stall = clearing || (f_valid && q_full);
  assign accept   = in_valid && !in_stall;
  assign q_push   = f_valid && !q_full;

  // Particle type magnitude; the most negative code has magnitude 128.
  assign mag    = particle_code[CODE_W-1] ? (~particle_code + 1'b1) : particle_code;
  assign mag_m1 = mag - 1'b1;
  assign known  = (mag == 8'd1) || (mag == 8'd2) || (mag == 8'd3);

  // Energy above the offset, scaled into Q24 bins.
  assign diff = {1'b0, energy_kev} - {1'b0, energy_offset_kev};
  assign prod = PROD_W'(diff[ENERGY_W-1:0]) * PROD_W'(bin_scale);

  // Function decode.
  always_comb begin
    work        = 1'b1;
    op_dec      = OP_READ_NONE;
    species_dec = '0;
    case (func)
      FUNC_RECORD: begin
        op_dec      = known ? OP_RECORD : OP_COUNT;
        species_dec = known ? mag_m1[SPECIES_W-1:0] : '0;
      end
      FUNC_READ_BIN: begin
        if (32'(species_select) < SPECIES && 32'(bin_index) < MAX_BINS) begin
          op_dec      = OP_READ_BIN;
          species_dec = species_select;
        end
      end
      FUNC_READ_TOT: begin
        if (32'(species_select) < SPECIES) begin
          op_dec      = OP_READ_TOT;
          species_dec = species_select;
        end
      end
      default: begin
        work = 1'b0;
      end
    endcase
  end

  // Front register control.
  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (accept) begin
      f_valid <= work;
    end else if (q_push) begin
      f_valid <= 1'b0;
    end
  end

  // Front register payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      f_op      <= op_dec;
      f_species <= species_dec;
      f_energy  <= energy_kev;
      f_index   <= BIN_W'(bin_index);
      f_below   <= diff[ENERGY_W];
      f_prod    <= prod;
    end
  end

  // Bin limit check and store address of the queued word.
  assign raw_bin = f_prod[PROD_W-1:FRAC_W];
  assign slot    = (f_op == OP_RECORD) ? raw_bin[BIN_W-1:0] : f_index;

  always_comb begin
    q_item.op      = f_op;
    q_item.species = f_species;
    q_item.energy  = f_energy;
    q_item.hit     = !f_below
                     && (raw_bin < {{(RAW_BIN_W-NBINS_W){1'b0}}, num_bins})
                     && (raw_bin < RAW_BIN_W'(MAX_BINS));
    q_item.addr    = ADDR_W'(f_species) * ADDR_W'(MAX_BINS) + ADDR_W'(slot);
  end

endmodule

`default_nettype wire

/* rtl/core/phe_queue.sv */
// ----------------------------------------------------------------------------
// phe_queue
// Short first-in first-out queue of decoded words between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module phe_queue (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire phe_pkg::phe_item_t push_item,
  input  wire logic               pop,
  output logic                    full,
  output logic                    not_empty,
  output phe_pkg::phe_item_t      head
);
  import phe_pkg::*;

  phe_item_t         entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] fill;

  assign full      = (fill == QCNT_W'(QUEUE_DEPTH));
  assign not_empty = (fill != '0);
  assign head      = entries[rd_ptr];

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/phe_back.sv */
// ----------------------------------------------------------------------------
// phe_back
// Carries out queued words: histogram read-modify-write, species sums and
// counts, the record total, and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module phe_back (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            q_valid,
  input  wire phe_pkg::phe_item_t              q_item,
  output logic                                 q_pop,
  output logic                                 clearing,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [phe_pkg::OUT_COUNT_W-1:0]      bin_value,
  output logic [phe_pkg::OUT_SUM_W-1:0]        energy_sum,
  output logic [phe_pkg::OUT_COUNT_W-1:0]      species_total,
  output logic [phe_pkg::OUT_COUNT_W-1:0]      all_records
);
  import phe_pkg::*;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_EXEC  = 2'd2;

  logic [1:0]             state;
  logic [ADDR_W-1:0]      clr_addr;
  phe_item_t              cur;
  logic [COUNT_WIDTH-1:0] rdata;
  logic [COUNT_WIDTH-1:0] hist_mem [MEM_DEPTH];
  logic [SUM_WIDTH-1:0]   sums   [SPECIES];
  logic [COUNT_WIDTH-1:0] counts [SPECIES];
  logic [COUNT_WIDTH-1:0] total;

  logic                   is_read;
  logic                   exec_go;
  logic                   mem_we;
  logic [ADDR_W-1:0]      mem_waddr;
  logic [COUNT_WIDTH-1:0] mem_wdata;

  // Saturating increment of a counter.
  function automatic logic [COUNT_WIDTH-1:0] count_up(input logic [COUNT_WIDTH-1:0] c);
    logic [COUNT_WIDTH:0] s;
    s = {1'b0, c} + 1'b1;
    return s[COUNT_WIDTH] ? '1 : s[COUNT_WIDTH-1:0];
  endfunction

  // Saturating add of an energy to a sum.
  function automatic logic [SUM_WIDTH-1:0] sum_add(input logic [SUM_WIDTH-1:0] a,
                                                   input logic [ENERGY_W-1:0] e);
    logic [SUM_WIDTH:0] s;
    s = {1'b0, a} + {1'b0, SUM_WIDTH'(e)};
    return s[SUM_WIDTH] ? '1 : s[SUM_WIDTH-1:0];
  endfunction

  assign clearing = (state == ST_CLEAR);
  assign q_pop    = (state == ST_IDLE) && q_valid;
  assign is_read  = (cur.op == OP_READ_BIN) || (cur.op == OP_READ_TOT)
                    || (cur.op == OP_READ_NONE);
  assign exec_go  = (state == ST_EXEC) && (!is_read || !out_valid || !out_stall);

  // Histogram write port: the clearing sweep, or a bin increment.
  assign mem_we    = clearing || (exec_go && cur.op == OP_RECORD && cur.hit);
  assign mem_waddr = clearing ? clr_addr : cur.addr;
  assign mem_wdata = clearing ? '0 : count_up(rdata);

  // Histogram store with registered read.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      hist_mem[mem_waddr] <= mem_wdata;
    end
    if (q_pop) begin
      rdata <= hist_mem[q_item.addr];
    end
  end

  // Sequencer, totals and result valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
      total     <= '0;
      for (int i = 0; i < SPECIES; i++) begin
        sums[i]   <= '0;
        counts[i] <= '0;
      end
    end else begin
      // A read loads a new result; otherwise an accepted result clears.
      if (exec_go && is_read) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == ADDR_W'(MEM_DEPTH - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (q_pop) begin
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (exec_go) begin
            state <= ST_IDLE;
            if (cur.op == OP_RECORD) begin
              sums[cur.species]   <= sum_add(sums[cur.species], cur.energy);
              counts[cur.species] <= count_up(counts[cur.species]);
              total               <= count_up(total);
            end else if (cur.op == OP_COUNT) begin
              total <= count_up(total);
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Current word and result payload.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_item;
    end
    if (exec_go && is_read) begin
      bin_value     <= (cur.op == OP_READ_BIN) ? OUT_COUNT_W'(rdata) : '0;
      energy_sum    <= (cur.op == OP_READ_TOT) ? OUT_SUM_W'(sums[cur.species]) : '0;
      species_total <= (cur.op == OP_READ_TOT) ? OUT_COUNT_W'(counts[cur.species]) : '0;
      all_records   <= OUT_COUNT_W'(total);
    end
  end

endmodule

`default_nettype wire

/* rtl/core/particle_energy_histogram_core.sv */
// ----------------------------------------------------------------------------
// particle_energy_histogram_core
// Per-species energy histogram with species sums, counts and a record total.
//
//   Channel  Direction  Handshake            Word
//   in       to core    in_valid/in_stall    func, particle_code, energy_kev,
//                                            species_select, bin_index
//   out      from core  out_valid/out_stall  bin_value, energy_sum,
//                                            species_total, all_records
//   cfg      to core    cfg_we               cfg_index, cfg_data
//
// The front registers the decoded word and its bin product. The back reads the
// histogram entry as it pops a word and, in its execute state, updates it or
// loads the result register. A result passes the front, queue, word and result
// registers; the back pops no new word until it leaves the execute state. After
// reset in_stall is high for the sweep that zeroes the store. A stalled result
// holds the back at a read word, the queue fills, then in_stall rises.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module particle_energy_histogram_core (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic [phe_pkg::FUNC_W-1:0]          func,
  input  wire logic signed [phe_pkg::CODE_W-1:0]   particle_code,
  input  wire logic [phe_pkg::ENERGY_W-1:0]        energy_kev,
  input  wire logic [phe_pkg::SPECIES_W-1:0]       species_select,
  input  wire logic [phe_pkg::BIDX_W-1:0]          bin_index,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic [phe_pkg::OUT_COUNT_W-1:0]          bin_value,
  output logic [phe_pkg::OUT_SUM_W-1:0]            energy_sum,
  output logic [phe_pkg::OUT_COUNT_W-1:0]          species_total,
  output logic [phe_pkg::OUT_COUNT_W-1:0]          all_records,
  input  wire logic                                cfg_we,
  input  wire logic [phe_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  wire logic [phe_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import phe_pkg::*;

  logic [OFFSET_W-1:0] energy_offset_kev;
  logic [SCALE_W-1:0]  bin_scale;
  logic [NBINS_W-1:0]  num_bins;

  logic      clearing;
  logic      q_push;
  logic      q_pop;
  logic      q_full;
  logic      q_valid;
  phe_item_t push_item;
  phe_item_t head_item;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      energy_offset_kev <= OFFSET_RESET;
      bin_scale         <= SCALE_RESET;
      num_bins          <= NBINS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_OFFSET: energy_offset_kev <= cfg_data[OFFSET_W-1:0];
        CFG_SCALE:  bin_scale         <= cfg_data[SCALE_W-1:0];
        CFG_NBINS:  num_bins          <= cfg_data[NBINS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Front: accept and decode.
  phe_front u_front (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .func              (func),
    .particle_code     (particle_code),
    .energy_kev        (energy_kev),
    .species_select    (species_select),
    .bin_index         (bin_index),
    .energy_offset_kev (energy_offset_kev),
    .bin_scale         (bin_scale),
    .num_bins          (num_bins),
    .clearing          (clearing),
    .q_full            (q_full),
    .q_push            (q_push),
    .q_item            (push_item)
  );

  // Queue between front and back.
  phe_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (push_item),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_valid),
    .head      (head_item)
  );

  // Back: store updates and results.
  phe_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_item        (head_item),
    .q_pop         (q_pop),
    .clearing      (clearing),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .bin_value     (bin_value),
    .energy_sum    (energy_sum),
    .species_total (species_total),
    .all_records   (all_records)
  );

  // Checks across front, queue and back.
  `PHE_ASSERT_NEVER(a_no_accept_in_clear, clearing && in_valid && !in_stall, "taken in sweep")
  `PHE_ASSERT_IMPL(a_no_result_in_clear, out_valid, !clearing, "result during clearing sweep")
  `PHE_ASSERT_IMPL(a_clear_after_reset, $past(rst), clearing, "no sweep after reset")
  `PHE_ASSERT_IMPL(a_pop_needs_word, q_pop, q_valid, "back took a word from an empty queue")

endmodule

`default_nettype wire
